// File: rtl/block_buffer_cache_lru_assert.svh
// Assertion macros used by the buffer cache top level.
`ifndef BLOCK_BUFFER_CACHE_LRU_ASSERT_SVH
`define BLOCK_BUFFER_CACHE_LRU_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define BBC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("buffer cache assertion failed");

// Next-cycle implication, held off during reset.
`define BBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("buffer cache assertion failed");

`endif

// File: rtl/bbc_pkg.sv
// Types and constants of the buffer cache.
`timescale 1ns / 1ps
package bbc_pkg;

	// Index width that covers every supported table size (up to 256 entries).
	localparam int IDXW = 8;
	localparam logic [7:0] COUNT_TOP = 8'hFF;

	typedef enum logic [1:0] {
		KIND_ACQUIRE = 2'd0,
		KIND_RELEASE = 2'd1,
		KIND_PIN     = 2'd2,
		KIND_UNPIN   = 2'd3
	} kind_e;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NO_FREE   = 2'd1,
		STAT_UNDERFLOW = 2'd2
	} status_e;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SWEEP,
		S_EXEC
	} state_e;

	typedef struct packed {
		logic [7:0]  device;
		logic [31:0] block_number;
	} key_t;

	// Search word passed from cell to cell.
	typedef struct packed {
		logic            valid;
		logic            hit;
		logic [IDXW-1:0] hit_idx;
		logic            free;
		logic [31:0]     best_time;
		logic [IDXW-1:0] best_idx;
	} carry_t;

	// Update broadcast to the cells.
	typedef struct packed {
		logic            we;
		logic [IDXW-1:0] idx;
		logic            set_tag;
		key_t            key;
		logic [7:0]      cnt;
		logic            set_time;
		logic [31:0]     now;
		logic            set_loaded;
	} cmd_t;

	typedef struct packed {
		logic [7:0] cnt;
		logic       loaded;
	} stat_t;

endpackage

// File: rtl/bbc_in_if.sv
// Request channel of the buffer cache.
`timescale 1ns / 1ps
interface bbc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  device;
	logic [31:0] block_number;
	logic [4:0]  entry;
	logic [31:0] now;

	modport source (output valid, kind, device, block_number, entry, now, input ready);
	modport sink (input valid, kind, device, block_number, entry, now, output ready);
endinterface

// File: rtl/bbc_out_if.sv
// Response channel of the buffer cache.
`timescale 1ns / 1ps
interface bbc_out_if;
	logic       valid;
	logic       ready;
	logic [4:0] entry_out;
	logic       hit;
	logic       need_read;
	logic [1:0] status;
	logic [7:0] use_count;

	modport source (output valid, entry_out, hit, need_read, status, use_count, input ready);
	modport sink (input valid, entry_out, hit, need_read, status, use_count, output ready);
endinterface

// File: rtl/bbc_cell.sv
// One buffer entry: tag, count, time, flags, and one stage of the search chain.
`timescale 1ns / 1ps
module bbc_cell #(
	parameter int IDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  bbc_pkg::key_t   key,
	input  bbc_pkg::carry_t carry_in,
	output bbc_pkg::carry_t carry_out,
	input  bbc_pkg::cmd_t   cmd,
	output bbc_pkg::stat_t  stat
);

	logic        mapped_q;
	logic        loaded_q;
	logic [7:0]  cnt_q;
	logic [31:0] last_q;
	logic [7:0]  tag_dev_q;
	logic [31:0] tag_blk_q;

	bbc_pkg::carry_t carry_d;
	bbc_pkg::carry_t carry_q;
	logic            match;
	logic            free;
	logic            sel;

	assign match = mapped_q && (tag_dev_q == key.device) && (tag_blk_q == key.block_number);
	assign free  = !mapped_q || (cnt_q == 8'd0);
	assign sel   = cmd.we && (cmd.idx == bbc_pkg::IDXW'(IDX));

	// Fold this entry into the passing search word.
	always_comb begin
		carry_d = carry_in;
		if (!carry_in.hit && match) begin
			carry_d.hit     = 1'b1;
			carry_d.hit_idx = bbc_pkg::IDXW'(IDX);
		end
		if (free && (!carry_in.free || (last_q < carry_in.best_time))) begin
			carry_d.free      = 1'b1;
			carry_d.best_time = last_q;
			carry_d.best_idx  = bbc_pkg::IDXW'(IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
		end else begin
			carry_q <= carry_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapped_q <= 1'b0;
			loaded_q <= 1'b0;
			cnt_q    <= 8'd0;
			last_q   <= 32'd0;
		end else if (sel) begin
			cnt_q <= cmd.cnt;
			if (cmd.set_tag) begin
				mapped_q <= 1'b1;
			end
			if (cmd.set_loaded) begin
				loaded_q <= 1'b1;
			end
			if (cmd.set_time) begin
				last_q <= cmd.now;
			end
		end
	end

	// Tags matter only while mapped.
	always_ff @(posedge clk) begin
		if (sel && cmd.set_tag) begin
			tag_dev_q <= cmd.key.device;
			tag_blk_q <= cmd.key.block_number;
		end
	end

	assign carry_out  = carry_q;
	assign stat.cnt    = cnt_q;
	assign stat.loaded = loaded_q;

endmodule

// File: rtl/bbc_ctrl.sv
// Request sequencer: launches the search, applies the update, holds the response.
`timescale 1ns / 1ps
module bbc_ctrl #(
	parameter int ENTRIES = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	bbc_in_if.sink          req,
	bbc_out_if.source       rsp,
	output bbc_pkg::key_t   key,
	output bbc_pkg::carry_t launch,
	input  bbc_pkg::carry_t last,
	input  bbc_pkg::stat_t  stat [ENTRIES],
	output bbc_pkg::cmd_t   cmd
);

	bbc_pkg::state_e state_q, state_d;

	bbc_pkg::kind_e  kind_q;
	bbc_pkg::key_t   key_q;
	logic [4:0]      entry_q;
	logic [31:0]     now_q;
	logic            start_q;
	bbc_pkg::carry_t res_q;

	logic       rsp_valid_q;
	logic [4:0] entry_out_q;
	logic       hit_q;
	logic       need_read_q;
	logic [1:0] status_q;
	logic [7:0] use_count_q;

	logic                     out_free;
	logic                     exec_go;
	logic                     accept;
	logic [bbc_pkg::IDXW-1:0] tgt;
	bbc_pkg::stat_t           rd;
	logic                     in_range;
	logic [7:0]               inc;
	logic [7:0]               dec;

	logic            o_hit;
	logic            o_need_read;
	bbc_pkg::status_e o_status;
	logic [7:0]      o_cnt;
	logic [4:0]      o_entry;
	bbc_pkg::cmd_t   upd;

	assign out_free = !rsp_valid_q || rsp.ready;
	assign accept   = req.valid && req.ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			bbc_pkg::S_IDLE: begin
				if (req.valid) begin
					state_d = (bbc_pkg::kind_e'(req.kind) == bbc_pkg::KIND_ACQUIRE) ?
						bbc_pkg::S_SWEEP : bbc_pkg::S_EXEC;
				end
			end
			bbc_pkg::S_SWEEP: begin
				if (last.valid) begin
					state_d = bbc_pkg::S_EXEC;
				end
			end
			bbc_pkg::S_EXEC: begin
				if (out_free) begin
					state_d = bbc_pkg::S_IDLE;
				end
			end
			default: state_d = bbc_pkg::S_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		req.ready = 1'b0;
		exec_go   = 1'b0;
		case (state_q)
			bbc_pkg::S_IDLE:  req.ready = 1'b1;
			bbc_pkg::S_SWEEP: req.ready = 1'b0;
			bbc_pkg::S_EXEC:  exec_go   = out_free;
			default:          req.ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbc_pkg::S_IDLE;
			start_q <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= accept && (bbc_pkg::kind_e'(req.kind) == bbc_pkg::KIND_ACQUIRE);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= bbc_pkg::kind_e'(req.kind);
			key_q   <= {req.device, req.block_number};
			entry_q <= req.entry;
			now_q   <= req.now;
		end
		if (last.valid) begin
			res_q <= last;
		end
	end

	assign key = key_q;

	always_comb begin
		launch       = '0;
		launch.valid = start_q;
	end

	// Pick the entry the operation works on and read its count.
	always_comb begin
		if (kind_q == bbc_pkg::KIND_ACQUIRE) begin
			tgt = res_q.hit ? res_q.hit_idx : res_q.best_idx;
		end else begin
			tgt = bbc_pkg::IDXW'(entry_q);
		end
	end

	always_comb begin
		rd = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (tgt == bbc_pkg::IDXW'(i)) begin
				rd = stat[i];
			end
		end
	end

	assign in_range = int'(entry_q) < ENTRIES;
	assign inc      = (rd.cnt == bbc_pkg::COUNT_TOP) ? rd.cnt : rd.cnt + 8'd1;
	assign dec      = rd.cnt - 8'd1;

	always_comb begin
		upd         = '0;
		upd.idx     = tgt;
		upd.key     = key_q;
		upd.now     = now_q;
		o_entry     = entry_q;
		o_hit       = 1'b0;
		o_need_read = 1'b0;
		o_status    = bbc_pkg::STAT_OK;
		o_cnt       = 8'd0;
		case (kind_q)
			bbc_pkg::KIND_ACQUIRE: begin
				if (res_q.hit) begin
					o_entry        = tgt[4:0];
					o_hit          = 1'b1;
					o_need_read    = !rd.loaded;
					o_cnt          = inc;
					upd.we         = 1'b1;
					upd.cnt        = inc;
					upd.set_loaded = 1'b1;
				end else if (res_q.free) begin
					o_entry        = tgt[4:0];
					o_need_read    = 1'b1;
					o_cnt          = 8'd1;
					upd.we         = 1'b1;
					upd.set_tag    = 1'b1;
					upd.cnt        = 8'd1;
					upd.set_loaded = 1'b1;
				end else begin
					o_entry  = 5'd0;
					o_status = bbc_pkg::STAT_NO_FREE;
				end
			end
			bbc_pkg::KIND_PIN: begin
				if (in_range) begin
					o_cnt   = inc;
					upd.we  = 1'b1;
					upd.cnt = inc;
				end
			end
			bbc_pkg::KIND_RELEASE, bbc_pkg::KIND_UNPIN: begin
				if (in_range) begin
					if (rd.cnt == 8'd0) begin
						o_status = bbc_pkg::STAT_UNDERFLOW;
					end else begin
						o_cnt        = dec;
						upd.we       = 1'b1;
						upd.cnt      = dec;
						upd.set_time = (kind_q == bbc_pkg::KIND_RELEASE) && (dec == 8'd0);
					end
				end
			end
			default: o_status = bbc_pkg::STAT_OK;
		endcase
	end

	always_comb begin
		cmd    = upd;
		cmd.we = upd.we && exec_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (exec_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			entry_out_q <= o_entry;
			hit_q       <= o_hit;
			need_read_q <= o_need_read;
			status_q    <= o_status;
			use_count_q <= o_cnt;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.entry_out = entry_out_q;
	assign rsp.hit       = hit_q;
	assign rsp.need_read = need_read_q;
	assign rsp.status    = status_q;
	assign rsp.use_count = use_count_q;

endmodule

// File: rtl/block_buffer_cache_lru.sv
// Top level of the LRU buffer cache with reference counts.
//
//   channel  dir  payload                                        word taken when
//   req      in   kind, device, block_number, entry, now          req.valid && req.ready
//   rsp      out  entry_out, hit, need_read, status, use_count    rsp.valid && rsp.ready
//
// Release, pin and unpin go from the request register straight to the update; acquire
// first waits for the search word walking the cell chain one entry per cycle.
// One request is in flight at a time; the response register frees the request side,
// so a new word is taken while the previous response still waits on rsp.ready.
// Reset clears every entry at once (unmapped, count zero, time zero); no clearing pass.
// A stalled response holds the update back: the table changes only when the response
// is written.
`timescale 1ns / 1ps
`include "block_buffer_cache_lru_assert.svh"
module block_buffer_cache_lru #(
	parameter int ENTRIES = 32
) (
	input logic       clk,
	input logic       arst_n,
	bbc_in_if.sink    req,
	bbc_out_if.source rsp
);

	bbc_pkg::key_t   key;
	bbc_pkg::carry_t launch;
	bbc_pkg::cmd_t   cmd;
	bbc_pkg::carry_t chain [ENTRIES+1];
	bbc_pkg::stat_t  stat [ENTRIES];
	logic [ENTRIES-1:0] chain_vld;

	// Sequencer: takes the request, starts the search, commits the update and
	// drives the response register.
	bbc_ctrl #(
		.ENTRIES(ENTRIES)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.key    (key),
		.launch (launch),
		.last   (chain[ENTRIES]),
		.stat   (stat),
		.cmd    (cmd)
	);

	// Feed the search word into the first cell.
	assign chain[0] = launch;

	// Row of entries. Each cell checks its tag for a hit and keeps the oldest free
	// entry in the passing word, then hands the word to its neighbor next cycle.
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		bbc_cell #(
			.IDX(i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.key       (key),
			.carry_in  (chain[i]),
			.carry_out (chain[i+1]),
			.cmd       (cmd),
			.stat      (stat[i])
		);
		assign chain_vld[i] = chain[i+1].valid;
	end

	// Only one search word travels the chain at a time.
	`BBC_ASSERT_IMPL(a_one_word, clk, arst_n, 1'b1, $countones({chain_vld, launch.valid}) <= 1)
	// An idle sequencer has no search in flight.
	`BBC_ASSERT_IMPL(a_idle_chain, clk, arst_n, req.ready, chain_vld == '0 && !launch.valid)
	// An accepted acquire launches a search next cycle.
	`BBC_ASSERT_NEXT(a_launch, clk, arst_n,
		req.valid && req.ready && req.kind == bbc_pkg::KIND_ACQUIRE, launch.valid)
	// Every table update comes with a response.
	`BBC_ASSERT_NEXT(a_cmd_rsp, clk, arst_n, cmd.we, rsp.valid)

endmodule

// File: verif/block_buffer_cache_lru_tb.sv
// Self-checking testbench of the LRU buffer cache: directed table, saturation run and random traffic.
`timescale 1ns / 1ps
module block_buffer_cache_lru_tb;

	localparam int NBUF = 32;
	localparam int POOL = 48;
	localparam int HOLDOFF_CYCLES = 400;

	// One request word as the block sees it.
	typedef struct packed {
		bbc_pkg::kind_e kind;
		logic [7:0]     device;
		logic [31:0]    block_number;
		logic [4:0]     entry;
		logic [31:0]    now;
	} req_t;

	// One response word.
	typedef struct packed {
		logic [4:0]       entry_out;
		logic             hit;
		logic             need_read;
		bbc_pkg::status_e status;
		logic [7:0]       use_count;
	} rsp_t;

	// Directed row: a request and, where obvious, the response typed in by hand.
	typedef struct packed {
		req_t word;
		bit   typed;
		rsp_t want;
	} script_row_t;

	typedef struct packed {
		logic [7:0]  device;
		logic [31:0] block_number;
	} tag_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bbc_in_if  req_ch ();
	bbc_out_if rsp_ch ();

	block_buffer_cache_lru #(.ENTRIES(NBUF)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the buffer table, advanced once per accepted request word.
	logic [7:0]  c_dev    [NBUF];
	logic [31:0] c_blk    [NBUF];
	logic [7:0]  c_cnt    [NBUF];
	logic [31:0] c_stamp  [NBUF];
	bit          c_mapped [NBUF];
	bit          c_loaded [NBUF];

	rsp_t due_rsp [$];      // responses still owed by the block, oldest first
	rsp_t last_result;      // shadow response of the most recent accepted word
	tag_t tag_pool [POOL];  // recurring tags, so acquires hit and evict

	int req_idle_pct = 19;
	int rsp_idle_pct = 72;
	int holdoff_asked = 0;
	int words_sent = 0;
	int rsp_seen = 0;
	int mismatches = 0;
	int n_hits = 0, n_miss = 0, n_full = 0, n_under = 0, n_top = 0;
	logic [31:0] tick = '0;

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH t=%0t rsp#%0d %s: got 0x%0h, expected 0x%0h",
			$time, rsp_seen, what, got, want);
		mismatches++;
	endtask

	// Shadow of the buffer cache: apply one word to the table copy and return the
	// response the block must give for it.
	function automatic rsp_t cache_apply(req_t w);
		rsp_t r;
		int   pick;
		int   e;
		bit   found;
		r = '0;
		pick = 0;
		found = 1'b0;
		if (w.kind == bbc_pkg::KIND_ACQUIRE) begin
			// look for a mapped entry with the same device and block
			for (int i = 0; i < NBUF; i++) begin
				if (!found && c_mapped[i] && c_dev[i] == w.device &&
						c_blk[i] == w.block_number) begin
					pick = i;
					found = 1'b1;
				end
			end
			if (found) begin
				if (c_cnt[pick] != bbc_pkg::COUNT_TOP)
					c_cnt[pick]++;
				r.entry_out = pick[4:0];
				r.hit = 1'b1;
				r.need_read = !c_loaded[pick];
				c_loaded[pick] = 1'b1;
				r.use_count = c_cnt[pick];
				n_hits++;
			end else begin
				// least recently released free entry; strict compare keeps the lowest index on ties
				for (int i = 0; i < NBUF; i++) begin
					if ((!c_mapped[i] || c_cnt[i] == 0) &&
							(!found || c_stamp[i] < c_stamp[pick])) begin
						pick = i;
						found = 1'b1;
					end
				end
				if (!found) begin
					r.status = bbc_pkg::STAT_NO_FREE;
					n_full++;
				end else begin
					c_mapped[pick] = 1'b1;
					c_dev[pick] = w.device;
					c_blk[pick] = w.block_number;
					c_cnt[pick] = 8'd1;
					c_loaded[pick] = 1'b1;
					r.entry_out = pick[4:0];
					r.need_read = 1'b1;
					r.use_count = 8'd1;
					n_miss++;
				end
			end
		end else if (w.entry >= NBUF) begin
			r.entry_out = w.entry;
		end else begin
			e = int'(w.entry);
			if (w.kind == bbc_pkg::KIND_PIN) begin
				if (c_cnt[e] != bbc_pkg::COUNT_TOP)
					c_cnt[e]++;
			end else if (c_cnt[e] == 0) begin
				r.status = bbc_pkg::STAT_UNDERFLOW;
				n_under++;
			end else begin
				c_cnt[e]--;
				if (w.kind == bbc_pkg::KIND_RELEASE && c_cnt[e] == 0)
					c_stamp[e] = w.now;
			end
			r.entry_out = w.entry;
			r.use_count = c_cnt[e];
		end
		if (r.use_count == bbc_pkg::COUNT_TOP)
			n_top++;
		return r;
	endfunction

	// Pick a random entry that still holds a count; -1 when none does.
	function automatic int pick_held();
		int held [$];
		for (int i = 0; i < NBUF; i++)
			if (c_cnt[i] != 0)
				held.push_back(i);
		if (held.size() == 0)
			return -1;
		return held[$urandom_range(held.size() - 1)];
	endfunction

	// Offer one word on the request channel, hold it until taken, then record
	// the response it owes. Gaps before the word lower valid for whole cycles.
	task automatic offer_word(req_t w, bit typed, rsp_t want);
		rsp_t guess;
		while ($urandom_range(99) < req_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.kind         <= w.kind;
		req_ch.device       <= w.device;
		req_ch.block_number <= w.block_number;
		req_ch.entry        <= w.entry;
		req_ch.now          <= w.now;
		@(posedge clk);
		// valid is high at this edge; the word is taken at the first edge with ready
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		guess = cache_apply(w);
		last_result = guess;
		due_rsp.push_back(typed ? want : guess);
		words_sent++;
	endtask

	task automatic send_acquire(logic [7:0] d, logic [31:0] b);
		req_t w;
		w = '0;
		w.kind = bbc_pkg::KIND_ACQUIRE;
		w.device = d;
		w.block_number = b;
		w.entry = 5'($urandom);
		w.now = $urandom;
		offer_word(w, 1'b0, '0);
	endtask

	// Release, pin or unpin; now follows a rising tick, with an odd wild value.
	task automatic send_entry_op(bbc_pkg::kind_e k, int e);
		req_t w;
		w = '0;
		tick += $urandom_range(1, 50);
		w.kind = k;
		w.device = 8'($urandom);
		w.block_number = $urandom;
		w.entry = e[4:0];
		w.now = ($urandom_range(19) == 0) ? $urandom : tick;
		offer_word(w, 1'b0, '0);
	endtask

	function automatic script_row_t row(bbc_pkg::kind_e k, logic [7:0] d, logic [31:0] b,
			logic [4:0] e, logic [31:0] t, bit typed, logic [4:0] eo, logic h,
			logic rd, bbc_pkg::status_e st, logic [7:0] cnt);
		script_row_t s;
		s.word = '{kind: k, device: d, block_number: b, entry: e, now: t};
		s.typed = typed;
		s.want = '{entry_out: eo, hit: h, need_read: rd, status: st, use_count: cnt};
		return s;
	endfunction

	// Response side: random stalls, plus one long hold-off on request.
	initial begin : rsp_drive
		int holdoff_left;
		int holdoff_seen;
		holdoff_left = 0;
		holdoff_seen = 0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (holdoff_left > 0) begin
				rsp_ch.ready <= 1'b0;
				holdoff_left--;
			end else if (holdoff_seen != holdoff_asked) begin
				// hold off long enough that the block fills and stalls its input
				holdoff_seen = holdoff_asked;
				holdoff_left = HOLDOFF_CYCLES;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
			end
		end
	end

	// Compare every response word, field by field, with the oldest one owed.
	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			rsp_seen++;
			if (due_rsp.size() == 0) begin
				report_mismatch("response with none owed", rsp_ch.entry_out, 0);
			end else begin
				want = due_rsp.pop_front();
				if (rsp_ch.entry_out !== want.entry_out)
					report_mismatch("entry_out", rsp_ch.entry_out, want.entry_out);
				if (rsp_ch.hit !== want.hit)
					report_mismatch("hit", rsp_ch.hit, want.hit);
				if (rsp_ch.need_read !== want.need_read)
					report_mismatch("need_read", rsp_ch.need_read, want.need_read);
				if (rsp_ch.status !== want.status)
					report_mismatch("status", rsp_ch.status, want.status);
				if (rsp_ch.use_count !== want.use_count)
					report_mismatch("use_count", rsp_ch.use_count, want.use_count);
			end
		end
	end

	initial begin : watchdog
		#10ms;
		$display("block_buffer_cache_lru regression: fail");
		$finish;
	end

	initial begin : stimulus
		script_row_t script [$];
		int phase_end [3];
		int hot;
		int r;
		int e;
		int e0;
		int free;
		int spin;

		req_ch.valid        <= 1'b0;
		req_ch.kind         <= bbc_pkg::KIND_ACQUIRE;
		req_ch.device       <= '0;
		req_ch.block_number <= '0;
		req_ch.entry        <= '0;
		req_ch.now          <= '0;

		for (int i = 0; i < NBUF; i++) begin
			c_dev[i] = '0;
			c_blk[i] = '0;
			c_cnt[i] = '0;
			c_stamp[i] = '0;
			c_mapped[i] = 1'b0;
			c_loaded[i] = 1'b0;
		end
		tag_pool[0] = '{8'h00, 32'h0000_0000};
		tag_pool[1] = '{8'hFF, 32'hFFFF_FFFF};
		for (int i = 2; i < POOL; i++)
			tag_pool[i] = '{8'($urandom), $urandom};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tick = $urandom;

		// Directed table. Typed rows are read straight off the behavior after reset:
		// counting on an unmapped entry, allocation in index order while all times
		// are zero, partial tag matches, underflow at zero.
		script.push_back(row(bbc_pkg::KIND_RELEASE, 8'h00, 32'h0, 5'd5, 32'h0, 1,
			5'd5, 0, 0, bbc_pkg::STAT_UNDERFLOW, 8'd0));
		script.push_back(row(bbc_pkg::KIND_UNPIN, 8'h00, 32'h0, 5'd31, 32'h0, 1,
			5'd31, 0, 0, bbc_pkg::STAT_UNDERFLOW, 8'd0));
		// pin acts on an unmapped entry; the entry stays free for allocation
		script.push_back(row(bbc_pkg::KIND_PIN, 8'h00, 32'h0, 5'd0, 32'h0, 1,
			5'd0, 0, 0, bbc_pkg::STAT_OK, 8'd1));
		script.push_back(row(bbc_pkg::KIND_ACQUIRE, 8'h00, 32'h0, 5'd0, 32'h0, 1,
			5'd0, 0, 1, bbc_pkg::STAT_OK, 8'd1));
		script.push_back(row(bbc_pkg::KIND_ACQUIRE, 8'h00, 32'h0, 5'd0, 32'h0, 1,
			5'd0, 1, 0, bbc_pkg::STAT_OK, 8'd2));
		script.push_back(row(bbc_pkg::KIND_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 5'd31,
			32'hFFFF_FFFF, 1, 5'd1, 0, 1, bbc_pkg::STAT_OK, 8'd1));
		script.push_back(row(bbc_pkg::KIND_ACQUIRE, 8'h00, 32'hFFFF_FFFF, 5'd0, 32'h0, 1,
			5'd2, 0, 1, bbc_pkg::STAT_OK, 8'd1));
		script.push_back(row(bbc_pkg::KIND_ACQUIRE, 8'hFF, 32'h0, 5'd0, 32'h0, 1,
			5'd3, 0, 1, bbc_pkg::STAT_OK, 8'd1));
		script.push_back(row(bbc_pkg::KIND_RELEASE, 8'h00, 32'h0, 5'd1, 32'hFFFF_FFFF, 1,
			5'd1, 0, 0, bbc_pkg::STAT_OK, 8'd0));
		script.push_back(row(bbc_pkg::KIND_RELEASE, 8'h00, 32'h0, 5'd2, 32'h0, 1,
			5'd2, 0, 0, bbc_pkg::STAT_OK, 8'd0));
		// least time wins among free entries; then a released tag is hit again
		script.push_back(row(bbc_pkg::KIND_ACQUIRE, 8'h05, 32'h1234_5678, 5'd0, 32'h0, 0,
			5'd0, 0, 0, bbc_pkg::STAT_OK, 8'd0));
		script.push_back(row(bbc_pkg::KIND_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'h0, 0,
			5'd0, 0, 0, bbc_pkg::STAT_OK, 8'd0));
		// unpin to zero stamps no time
		script.push_back(row(bbc_pkg::KIND_UNPIN, 8'h00, 32'h0, 5'd3, 32'hFFFF_FFFF, 0,
			5'd0, 0, 0, bbc_pkg::STAT_OK, 8'd0));
		script.push_back(row(bbc_pkg::KIND_UNPIN, 8'h00, 32'h0, 5'd3, 32'h0, 1,
			5'd3, 0, 0, bbc_pkg::STAT_UNDERFLOW, 8'd0));
		script.push_back(row(bbc_pkg::KIND_PIN, 8'h00, 32'h0, 5'd31, 32'h0, 1,
			5'd31, 0, 0, bbc_pkg::STAT_OK, 8'd1));
		script.push_back(row(bbc_pkg::KIND_RELEASE, 8'h00, 32'h0, 5'd31, 32'h7, 1,
			5'd31, 0, 0, bbc_pkg::STAT_OK, 8'd0));
		// evict a mapped free entry, then ask for its old tag again
		script.push_back(row(bbc_pkg::KIND_ACQUIRE, 8'hAA, 32'h5555_5555, 5'd0, 32'h0, 0,
			5'd0, 0, 0, bbc_pkg::STAT_OK, 8'd0));
		script.push_back(row(bbc_pkg::KIND_ACQUIRE, 8'hFF, 32'h0, 5'd0, 32'h0, 0,
			5'd0, 0, 0, bbc_pkg::STAT_OK, 8'd0));
		script.push_back(row(bbc_pkg::KIND_PIN, 8'h00, 32'h0, 5'd0, 32'h0, 0,
			5'd0, 0, 0, bbc_pkg::STAT_OK, 8'd0));
		script.push_back(row(bbc_pkg::KIND_RELEASE, 8'h00, 32'h0, 5'd0, 32'h8000_0000, 0,
			5'd0, 0, 0, bbc_pkg::STAT_OK, 8'd0));
		foreach (script[i])
			offer_word(script[i].word, script[i].typed, script[i].want);

		// Saturation: drive one entry to the count top, hit it there, then release
		// it back down to zero and one step past.
		send_acquire(8'h3C, 32'h0F0F_0F0F);
		hot = int'(last_result.entry_out);
		repeat (256) send_entry_op(bbc_pkg::KIND_PIN, hot);
		send_acquire(8'h3C, 32'h0F0F_0F0F);
		repeat (256) send_entry_op(bbc_pkg::KIND_RELEASE, hot);

		// Random traffic in three idling phases: sender light / receiver heavy,
		// the reverse, then no idling with one long response hold-off.
		phase_end[0] = 900;
		phase_end[1] = 1400;
		phase_end[2] = 1800;
		for (int p = 0; p < 3; p++) begin
			if (p == 1) begin
				req_idle_pct = 72;
				rsp_idle_pct = 19;
			end else if (p == 2) begin
				req_idle_pct = 0;
				rsp_idle_pct = 0;
				holdoff_asked++;
			end
			while (words_sent < phase_end[p]) begin
				r = $urandom_range(99);
				if (r < 60) begin
					// mixed workload over the tag pool
					repeat (40) begin
						r = $urandom_range(99);
						if (r < 45) begin
							if ($urandom_range(4) == 0)
								send_acquire(8'($urandom), $urandom);
							else begin
								e = $urandom_range(POOL - 1);
								send_acquire(tag_pool[e].device, tag_pool[e].block_number);
							end
						end else if (r < 75 || (r >= 85 && r < 95)) begin
							e = pick_held();
							if (e < 0)
								e = $urandom_range(NBUF - 1);
							send_entry_op(r < 75 ? bbc_pkg::KIND_RELEASE : bbc_pkg::KIND_UNPIN,
								e);
						end else if (r < 85) begin
							send_entry_op(bbc_pkg::KIND_PIN, $urandom_range(NBUF - 1));
						end else begin
							// noise: any entry, may underflow
							send_entry_op($urandom_range(1) ? bbc_pkg::KIND_RELEASE :
								bbc_pkg::KIND_UNPIN, $urandom_range(NBUF - 1));
						end
					end
				end else if (r < 80) begin
					// fill every entry with fresh tags, then ask past the end
					for (spin = 0; spin < NBUF + 8; spin++) begin
						free = 0;
						for (int i = 0; i < NBUF; i++)
							if (!c_mapped[i] || c_cnt[i] == 0)
								free++;
						if (free == 0)
							break;
						send_acquire(8'($urandom), $urandom);
					end
					repeat (2) send_acquire(8'($urandom), $urandom);
				end else begin
					// drain every count to zero from a random start, then underflow once
					e0 = $urandom_range(NBUF - 1);
					for (int k = 0; k < NBUF; k++) begin
						e = (e0 + k) % NBUF;
						while (c_cnt[e] != 0)
							send_entry_op($urandom_range(3) == 0 ? bbc_pkg::KIND_UNPIN :
								bbc_pkg::KIND_RELEASE, e);
					end
					send_entry_op(bbc_pkg::KIND_RELEASE, e0);
				end
			end
		end

		// Drop valid, wait for every owed response, then let the block settle.
		@(posedge clk);
		req_ch.valid <= 1'b0;
		for (spin = 0; spin < 20000 && due_rsp.size() != 0; spin++)
			@(posedge clk);
		repeat (NBUF + 8) @(posedge clk);
		if (due_rsp.size() != 0)
			report_mismatch("responses never returned", due_rsp.size(), 0);

		$display("covered %0d words: %0d hits, %0d misses, %0d no-free, %0d underflows,",
			words_sent, n_hits, n_miss, n_full, n_under);
		$display("  %0d responses at count top; %0d responses checked, %0d mismatches",
			n_top, rsp_seen, mismatches);
		if (mismatches == 0)
			$display("block_buffer_cache_lru regression: pass");
		else
			$display("block_buffer_cache_lru regression: fail");
		$finish;
	end

endmodule
